// ----- src/ffsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_ROW_MUL,
		ST_ROW_IDX,
		ST_COL_MUL,
		ST_COL_IDX,
		ST_PIX_RD,
		ST_PIX_MR,
		ST_PIX_MG,
		ST_PIX_MB,
		ST_PIX_WR,
		ST_SPL_RD,
		ST_SPL_WR,
		ST_RES_RD,
		ST_RES_MUL,
		ST_RES_DIV,
		ST_RES_SUM,
		ST_DONE
	} state_t;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_ADD     = 2'd1;
	localparam logic [1:0] OP_SPLAT   = 2'd2;
	localparam logic [1:0] OP_RESOLVE = 2'd3;

	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
	localparam logic [1:0] STAT_NO_PIXEL = 2'd2;

	localparam logic [2:0] REG_CROP_X_START  = 3'd0;
	localparam logic [2:0] REG_CROP_Y_START  = 3'd1;
	localparam logic [2:0] REG_CROP_X_COUNT  = 3'd2;
	localparam logic [2:0] REG_CROP_Y_COUNT  = 3'd3;
	localparam logic [2:0] REG_RADIUS_X      = 3'd4;
	localparam logic [2:0] REG_RADIUS_Y      = 3'd5;
	localparam logic [2:0] REG_INV_RADIUS_X  = 3'd6;
	localparam logic [2:0] REG_INV_RADIUS_Y  = 3'd7;

	localparam int CNTW = 13;

	localparam logic signed [23:0] COLOR_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] COLOR_MIN = -24'sh800000;

	function automatic logic signed [31:0] sat32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) begin
			sat32 = {s[32], {31{~s[32]}}};
		end else begin
			sat32 = s[31:0];
		end
	endfunction

endpackage
`default_nettype wire

// ----- src/ffsa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffsa_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic [NW-1:0]      quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   shifted;
	logic [DW+1:0] trial;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ----- src/film_filtered_sample_accumulator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake              Payload
// in        in_valid / in_ready    opcode, pos_x, pos_y, color_*, weight_*, splat_scale, pixel_*
// out       out_valid / out_ready  status, out_r, out_g, out_b
// cfg       cfg_we                 cfg_index, cfg_data
// After reset a clear pass zeroes every pixel, in_ready low. Loads and out-of-range items end
// at decode; an in-range splat reads and writes its pixel. Add: each covered row and pixel gets
// a multiply and index, each pixel a read, three products and a write; one shared multiplier
// does the table lookups and weight products. Resolve runs the bit-serial divider once per
// channel, skipped with a zero weight sum. One word is in work at a time; a finished word
// waits in the output register while the next is accepted; a full one holds the sequencer.
module film_filtered_sample_accumulator #(
	parameter int FILM_WIDTH  = 64,
	parameter int FILM_HEIGHT = 64,
	parameter int TABLE_SIDE  = 16,
	parameter int ACC_WIDTH   = 48
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] color_r,
	input  wire logic signed [15:0] color_g,
	input  wire logic signed [15:0] color_b,
	input  wire logic [7:0]         weight_index,
	input  wire logic signed [15:0] weight_value,
	input  wire logic [15:0]        splat_scale,
	input  wire logic [5:0]         pixel_col,
	input  wire logic [5:0]         pixel_row,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [23:0]      out_r,
	output logic signed [23:0]      out_g,
	output logic signed [23:0]      out_b,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [14:0]        cfg_data
);

	localparam int NPIX = FILM_WIDTH * FILM_HEIGHT;
	localparam int PAW  = (NPIX > 1) ? $clog2(NPIX) : 1;
	localparam int NTAB = TABLE_SIDE * TABLE_SIDE;
	localparam int TAW  = $clog2(NTAB);
	localparam int TW   = $clog2(TABLE_SIDE);
	localparam int AW   = ACC_WIDTH;
	localparam int AW1  = ACC_WIDTH + 1;
	localparam int SW   = (ACC_WIDTH + 2 > 46) ? ACC_WIDTH + 2 : 46;
	localparam int CW   = 16;
	localparam int CNTW = ffsa_pkg::CNTW;

	function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW-1:0] a,
		input logic signed [31:0] b);
		logic signed [AW:0] s;
		s = AW1'(a) + AW1'(b);
		if (s[AW] != s[AW-1]) begin
			sat_acc = {s[AW], {(AW-1){~s[AW]}}};
		end else begin
			sat_acc = s[AW-1:0];
		end
	endfunction

	ffsa_pkg::state_t st_q, st_d;

	logic [10:0] crop_x_start_q, crop_y_start_q;
	logic [6:0]  crop_x_count_q, crop_y_count_q, radius_x_q, radius_y_q;
	logic [14:0] inv_radius_x_q, inv_radius_y_q;

	logic [1:0]         opcode_q;
	logic signed [15:0] pos_x_q, pos_y_q, color_r_q, color_g_q, color_b_q, weight_value_q;
	logic [7:0]         weight_index_q;
	logic [15:0]        splat_scale_q;
	logic [5:0]         pixel_col_q, pixel_row_q;

	logic [PAW:0]    clr_q;
	logic [PAW-1:0]  addr_q;
	logic [TAW-1:0]  wt_addr_q;
	logic [TW-1:0]   iy_q;
	logic signed [CW-1:0] x_q, y_q, x0_q, x1_q, y1_q;
	logic [1:0]      ch_q;
	logic [1:0]      stat_q;
	logic signed [23:0] res_r_q, res_g_q, res_b_q;
	logic signed [AW-1:0] new_r_q, new_g_q;
	logic signed [51:0] prod_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [23:0] out_r_q, out_g_q, out_b_q;

	logic signed [15:0]   wt_rd_q;
	logic signed [AW-1:0] rd_r_q, rd_g_q, rd_b_q;
	logic signed [31:0]   rd_w_q, rd_sr_q, rd_sg_q, rd_sb_q;

	logic signed [15:0]   wt_mem [NTAB];
	logic signed [AW-1:0] acc_r_mem [NPIX];
	logic signed [AW-1:0] acc_g_mem [NPIX];
	logic signed [AW-1:0] acc_b_mem [NPIX];
	logic signed [31:0]   acc_w_mem [NPIX];
	logic signed [31:0]   spl_r_mem [NPIX];
	logic signed [31:0]   spl_g_mem [NPIX];
	logic signed [31:0]   spl_b_mem [NPIX];

	logic [CNTW-1:0] xc_c, yc_c;
	logic signed [16:0] dx_c, dy_c;
	logic signed [17:0] lox_c, hix_c, loy_c, hiy_c;
	logic signed [CW-1:0] x0r_c, x1r_c, y0r_c, y1r_c;
	logic signed [CW-1:0] xs_c, ys_c, xe_c, ye_c, x0_c, x1_c, y0_c, y1_c;
	logic               empty_c;
	logic signed [CW-1:0] spx_c, spy_c;
	logic               spl_in_c, res_in_c, load_in_c;
	logic [31:0]        spl_p_c, pix_p_c, res_p_c, wt_a_c, load_a_c;
	logic signed [20:0] difx_c, dify_c, magx_c, magy_c;
	logic [40:0]        tix_c;
	logic [TW-1:0]      tidx_c;

	logic                 mul_en;
	logic signed [32:0]   mul_a;
	logic signed [18:0]   mul_b;
	logic                 div_start;
	logic                 div_busy;
	logic [AW-1:0]        quo;
	logic [AW-1:0]        div_n;
	logic [31:0]          div_d;

	logic                 acc_we, spl_we, wt_we;
	logic [PAW-1:0]       waddr;
	logic signed [AW-1:0] wr_r, wr_g, wr_b;
	logic signed [31:0]   wr_w, wr_sr, wr_sg, wr_sb;

	logic signed [AW-1:0] acc_sel;
	logic signed [31:0]   spl_sel;
	logic                 neg_c;
	logic signed [SW-1:0] c_c, spt_c, sum_c;
	logic signed [23:0]   sat_c;
	logic                 last_x, last_y;

	// effective counts
	always_comb begin
		if (crop_x_count_q == 7'd0) begin
			xc_c = CNTW'(1);
		end else if (CNTW'(crop_x_count_q) > CNTW'(FILM_WIDTH)) begin
			xc_c = CNTW'(FILM_WIDTH);
		end else begin
			xc_c = CNTW'(crop_x_count_q);
		end
		if (crop_y_count_q == 7'd0) begin
			yc_c = CNTW'(1);
		end else if (CNTW'(crop_y_count_q) > CNTW'(FILM_HEIGHT)) begin
			yc_c = CNTW'(FILM_HEIGHT);
		end else begin
			yc_c = CNTW'(crop_y_count_q);
		end
	end

	// footprint and addresses
	always_comb begin
		dx_c  = 17'(pos_x_q) - 17'sd8;
		dy_c  = 17'(pos_y_q) - 17'sd8;
		lox_c = 18'(dx_c) - 18'(signed'({1'b0, radius_x_q}));
		hix_c = 18'(dx_c) + 18'(signed'({1'b0, radius_x_q}));
		loy_c = 18'(dy_c) - 18'(signed'({1'b0, radius_y_q}));
		hiy_c = 18'(dy_c) + 18'(signed'({1'b0, radius_y_q}));
		x0r_c = CW'((lox_c + 18'sd15) >>> 4);
		x1r_c = CW'(hix_c >>> 4);
		y0r_c = CW'((loy_c + 18'sd15) >>> 4);
		y1r_c = CW'(hiy_c >>> 4);
		xs_c  = CW'(signed'({1'b0, crop_x_start_q}));
		ys_c  = CW'(signed'({1'b0, crop_y_start_q}));
		xe_c  = xs_c + CW'(signed'({1'b0, xc_c})) - 16'sd1;
		ye_c  = ys_c + CW'(signed'({1'b0, yc_c})) - 16'sd1;
		x0_c  = (x0r_c < xs_c) ? xs_c : x0r_c;
		x1_c  = (x1r_c > xe_c) ? xe_c : x1r_c;
		y0_c  = (y0r_c < ys_c) ? ys_c : y0r_c;
		y1_c  = (y1r_c > ye_c) ? ye_c : y1r_c;
		empty_c = (x1_c < x0_c) || (y1_c < y0_c);

		spx_c = CW'(pos_x_q >>> 4);
		spy_c = CW'(pos_y_q >>> 4);
		spl_in_c = (spx_c >= xs_c) && (spx_c <= xe_c) && (spy_c >= ys_c) && (spy_c <= ye_c);
		spl_p_c = 32'(spy_c - ys_c) * 32'(FILM_WIDTH) + 32'(spx_c - xs_c);
		pix_p_c = 32'(y_q - ys_c) * 32'(FILM_WIDTH) + 32'(x_q - xs_c);

		res_in_c = (CNTW'(pixel_col_q) < xc_c) && (CNTW'(pixel_row_q) < yc_c);
		res_p_c  = 32'(pixel_row_q) * 32'(FILM_WIDTH) + 32'(pixel_col_q);

		load_a_c  = 32'(weight_index_q);
		load_in_c = load_a_c < 32'(NTAB);

		difx_c = (21'(x_q) <<< 4) - 21'(dx_c);
		dify_c = (21'(y_q) <<< 4) - 21'(dy_c);
		magx_c = (difx_c < 0) ? -difx_c : difx_c;
		magy_c = (dify_c < 0) ? -dify_c : dify_c;

		tix_c = 41'(prod_q[33:0]) * 41'(TABLE_SIDE);
		if (tix_c[40:16] > 25'(TABLE_SIDE - 1)) begin
			tidx_c = TW'(TABLE_SIDE - 1);
		end else begin
			tidx_c = tix_c[16+TW-1:16];
		end
		wt_a_c = 32'(iy_q) * 32'(TABLE_SIDE) + 32'(tidx_c);

		last_x = (x_q == x1_q);
		last_y = (y_q == y1_q);
	end

	// resolve arithmetic
	always_comb begin
		case (ch_q)
			2'd0: begin
				acc_sel = rd_r_q;
				spl_sel = rd_sr_q;
			end
			2'd1: begin
				acc_sel = rd_g_q;
				spl_sel = rd_sg_q;
			end
			default: begin
				acc_sel = rd_b_q;
				spl_sel = rd_sb_q;
			end
		endcase
		div_n = acc_sel[AW-1] ? AW'(-acc_sel) : AW'(acc_sel);
		div_d = rd_w_q[31] ? 32'(-rd_w_q) : 32'(rd_w_q);
		neg_c = acc_sel[AW-1] ^ rd_w_q[31];
		if (rd_w_q != 32'sd0) begin
			if (neg_c || quo == '0) begin
				c_c = '0;
			end else begin
				c_c = SW'(signed'({1'b0, quo}));
			end
		end else begin
			c_c = SW'(acc_sel >>> 15);
		end
		spt_c = SW'(prod_q >>> 8);
		sum_c = c_c + spt_c;
		if (sum_c > SW'(ffsa_pkg::COLOR_MAX)) begin
			sat_c = ffsa_pkg::COLOR_MAX;
		end else if (sum_c < SW'(ffsa_pkg::COLOR_MIN)) begin
			sat_c = ffsa_pkg::COLOR_MIN;
		end else begin
			sat_c = sum_c[23:0];
		end
	end

	ffsa_div #(
		.NW(AW),
		.DW(32)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quotient (quo)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ffsa_pkg::ST_CLEAR: begin
				if (clr_q == (PAW+1)'(NPIX - 1)) begin
					st_d = ffsa_pkg::ST_IDLE;
				end
			end
			ffsa_pkg::ST_IDLE: begin
				if (in_valid) begin
					st_d = ffsa_pkg::ST_DECODE;
				end
			end
			ffsa_pkg::ST_DECODE: begin
				case (opcode_q)
					ffsa_pkg::OP_ADD:
						st_d = empty_c ? ffsa_pkg::ST_DONE : ffsa_pkg::ST_ROW_MUL;
					ffsa_pkg::OP_SPLAT:
						st_d = spl_in_c ? ffsa_pkg::ST_SPL_RD : ffsa_pkg::ST_DONE;
					ffsa_pkg::OP_RESOLVE:
						st_d = res_in_c ? ffsa_pkg::ST_RES_RD : ffsa_pkg::ST_DONE;
					default:
						st_d = ffsa_pkg::ST_DONE;
				endcase
			end
			ffsa_pkg::ST_ROW_MUL: st_d = ffsa_pkg::ST_ROW_IDX;
			ffsa_pkg::ST_ROW_IDX: st_d = ffsa_pkg::ST_COL_MUL;
			ffsa_pkg::ST_COL_MUL: st_d = ffsa_pkg::ST_COL_IDX;
			ffsa_pkg::ST_COL_IDX: st_d = ffsa_pkg::ST_PIX_RD;
			ffsa_pkg::ST_PIX_RD:  st_d = ffsa_pkg::ST_PIX_MR;
			ffsa_pkg::ST_PIX_MR:  st_d = ffsa_pkg::ST_PIX_MG;
			ffsa_pkg::ST_PIX_MG:  st_d = ffsa_pkg::ST_PIX_MB;
			ffsa_pkg::ST_PIX_MB:  st_d = ffsa_pkg::ST_PIX_WR;
			ffsa_pkg::ST_PIX_WR: begin
				if (!last_x) begin
					st_d = ffsa_pkg::ST_COL_MUL;
				end else if (!last_y) begin
					st_d = ffsa_pkg::ST_ROW_MUL;
				end else begin
					st_d = ffsa_pkg::ST_DONE;
				end
			end
			ffsa_pkg::ST_SPL_RD: st_d = ffsa_pkg::ST_SPL_WR;
			ffsa_pkg::ST_SPL_WR: st_d = ffsa_pkg::ST_DONE;
			ffsa_pkg::ST_RES_RD: st_d = ffsa_pkg::ST_RES_MUL;
			ffsa_pkg::ST_RES_MUL: begin
				st_d = (rd_w_q != 32'sd0) ? ffsa_pkg::ST_RES_DIV : ffsa_pkg::ST_RES_SUM;
			end
			ffsa_pkg::ST_RES_DIV: begin
				if (!div_busy) begin
					st_d = ffsa_pkg::ST_RES_SUM;
				end
			end
			ffsa_pkg::ST_RES_SUM: begin
				st_d = (ch_q == 2'd2) ? ffsa_pkg::ST_DONE : ffsa_pkg::ST_RES_MUL;
			end
			ffsa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					st_d = ffsa_pkg::ST_IDLE;
				end
			end
			default: st_d = ffsa_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		acc_we    = 1'b0;
		spl_we    = 1'b0;
		wt_we     = 1'b0;
		waddr     = addr_q;
		wr_r      = '0;
		wr_g      = '0;
		wr_b      = '0;
		wr_w      = '0;
		wr_sr     = '0;
		wr_sg     = '0;
		wr_sb     = '0;
		case (st_q)
			ffsa_pkg::ST_CLEAR: begin
				acc_we = 1'b1;
				spl_we = 1'b1;
				waddr  = clr_q[PAW-1:0];
			end
			ffsa_pkg::ST_IDLE: in_ready = 1'b1;
			ffsa_pkg::ST_DECODE: begin
				wt_we = (opcode_q == ffsa_pkg::OP_LOAD) && load_in_c;
			end
			ffsa_pkg::ST_ROW_MUL: begin
				mul_en = 1'b1;
				mul_a  = signed'({18'd0, inv_radius_y_q});
				mul_b  = signed'({1'b0, magy_c[17:0]});
			end
			ffsa_pkg::ST_COL_MUL: begin
				mul_en = 1'b1;
				mul_a  = signed'({18'd0, inv_radius_x_q});
				mul_b  = signed'({1'b0, magx_c[17:0]});
			end
			ffsa_pkg::ST_PIX_MR: begin
				mul_en = 1'b1;
				mul_a  = 33'(wt_rd_q);
				mul_b  = 19'(color_r_q);
			end
			ffsa_pkg::ST_PIX_MG: begin
				mul_en = 1'b1;
				mul_a  = 33'(wt_rd_q);
				mul_b  = 19'(color_g_q);
			end
			ffsa_pkg::ST_PIX_MB: begin
				mul_en = 1'b1;
				mul_a  = 33'(wt_rd_q);
				mul_b  = 19'(color_b_q);
			end
			ffsa_pkg::ST_PIX_WR: begin
				acc_we = 1'b1;
				wr_r   = new_r_q;
				wr_g   = new_g_q;
				wr_b   = sat_acc(rd_b_q, prod_q[31:0]);
				wr_w   = ffsa_pkg::sat32(rd_w_q, 32'(wt_rd_q));
			end
			ffsa_pkg::ST_SPL_WR: begin
				spl_we = 1'b1;
				wr_sr  = ffsa_pkg::sat32(rd_sr_q, 32'(color_r_q));
				wr_sg  = ffsa_pkg::sat32(rd_sg_q, 32'(color_g_q));
				wr_sb  = ffsa_pkg::sat32(rd_sb_q, 32'(color_b_q));
			end
			ffsa_pkg::ST_RES_MUL: begin
				mul_en    = 1'b1;
				mul_a     = 33'(spl_sel);
				mul_b     = signed'({3'd0, splat_scale_q});
				div_start = (rd_w_q != 32'sd0);
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ffsa_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ffsa_pkg::ST_CLEAR) begin
				clr_q <= clr_q + (PAW+1)'(1);
			end
			if (st_q == ffsa_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_x_start_q <= 11'd0;
			crop_y_start_q <= 11'd0;
			crop_x_count_q <= 7'd64;
			crop_y_count_q <= 7'd64;
			radius_x_q     <= 7'd8;
			radius_y_q     <= 7'd8;
			inv_radius_x_q <= 15'd8192;
			inv_radius_y_q <= 15'd8192;
		end else if (cfg_we) begin
			case (cfg_index)
				ffsa_pkg::REG_CROP_X_START: crop_x_start_q <= cfg_data[10:0];
				ffsa_pkg::REG_CROP_Y_START: crop_y_start_q <= cfg_data[10:0];
				ffsa_pkg::REG_CROP_X_COUNT: crop_x_count_q <= cfg_data[6:0];
				ffsa_pkg::REG_CROP_Y_COUNT: crop_y_count_q <= cfg_data[6:0];
				ffsa_pkg::REG_RADIUS_X:     radius_x_q     <= cfg_data[6:0];
				ffsa_pkg::REG_RADIUS_Y:     radius_y_q     <= cfg_data[6:0];
				ffsa_pkg::REG_INV_RADIUS_X: inv_radius_x_q <= cfg_data;
				ffsa_pkg::REG_INV_RADIUS_Y: inv_radius_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (in_valid && in_ready) begin
			opcode_q       <= opcode;
			pos_x_q        <= pos_x;
			pos_y_q        <= pos_y;
			color_r_q      <= color_r;
			color_g_q      <= color_g;
			color_b_q      <= color_b;
			weight_index_q <= weight_index;
			weight_value_q <= weight_value;
			splat_scale_q  <= splat_scale;
			pixel_col_q    <= pixel_col;
			pixel_row_q    <= pixel_row;
		end
		case (st_q)
			ffsa_pkg::ST_DECODE: begin
				res_r_q <= '0;
				res_g_q <= '0;
				res_b_q <= '0;
				ch_q    <= 2'd0;
				x_q     <= x0_c;
				y_q     <= y0_c;
				x0_q    <= x0_c;
				x1_q    <= x1_c;
				y1_q    <= y1_c;
				stat_q  <= ffsa_pkg::STAT_DONE;
				case (opcode_q)
					ffsa_pkg::OP_ADD: begin
						if (empty_c) begin
							stat_q <= ffsa_pkg::STAT_OUTSIDE;
						end
					end
					ffsa_pkg::OP_SPLAT: begin
						addr_q <= spl_p_c[PAW-1:0];
						if (!spl_in_c) begin
							stat_q <= ffsa_pkg::STAT_OUTSIDE;
						end
					end
					ffsa_pkg::OP_RESOLVE: begin
						addr_q <= res_p_c[PAW-1:0];
						if (!res_in_c) begin
							stat_q <= ffsa_pkg::STAT_NO_PIXEL;
						end
					end
					default: begin
					end
				endcase
			end
			ffsa_pkg::ST_ROW_IDX: iy_q <= tidx_c;
			ffsa_pkg::ST_COL_IDX: begin
				wt_addr_q <= wt_a_c[TAW-1:0];
				addr_q    <= pix_p_c[PAW-1:0];
			end
			ffsa_pkg::ST_PIX_MG: new_r_q <= sat_acc(rd_r_q, prod_q[31:0]);
			ffsa_pkg::ST_PIX_MB: new_g_q <= sat_acc(rd_g_q, prod_q[31:0]);
			ffsa_pkg::ST_PIX_WR: begin
				if (!last_x) begin
					x_q <= x_q + 16'sd1;
				end else begin
					x_q <= x0_q;
					y_q <= y_q + 16'sd1;
				end
			end
			ffsa_pkg::ST_RES_SUM: begin
				case (ch_q)
					2'd0: res_r_q <= sat_c;
					2'd1: res_g_q <= sat_c;
					default: res_b_q <= sat_c;
				endcase
				ch_q <= ch_q + 2'd1;
			end
			ffsa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					status_q <= stat_q;
					out_r_q  <= res_r_q;
					out_g_q  <= res_g_q;
					out_b_q  <= res_b_q;
				end
			end
			default: begin
			end
		endcase
	end

	// filter table
	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[load_a_c[TAW-1:0]] <= weight_value_q;
		end
		wt_rd_q <= wt_mem[wt_addr_q];
	end

	// pixel sums
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_r_mem[waddr] <= wr_r;
			acc_g_mem[waddr] <= wr_g;
			acc_b_mem[waddr] <= wr_b;
			acc_w_mem[waddr] <= wr_w;
		end
		if (spl_we) begin
			spl_r_mem[waddr] <= wr_sr;
			spl_g_mem[waddr] <= wr_sg;
			spl_b_mem[waddr] <= wr_sb;
		end
		rd_r_q  <= acc_r_mem[addr_q];
		rd_g_q  <= acc_g_mem[addr_q];
		rd_b_q  <= acc_b_mem[addr_q];
		rd_w_q  <= acc_w_mem[addr_q];
		rd_sr_q <= spl_r_mem[addr_q];
		rd_sg_q <= spl_g_mem[addr_q];
		rd_sb_q <= spl_b_mem[addr_q];
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_r     = out_r_q;
	assign out_g     = out_g_q;
	assign out_b     = out_b_q;

`ifndef SYNTHESIS
	a_no_pixel_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ffsa_pkg::STAT_NO_PIXEL) |->
		(out_r == 24'sd0 && out_g == 24'sd0 && out_b == 24'sd0))
		else $error("pixel outside stored area returned color");
	a_pix_in_footprint: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ffsa_pkg::ST_PIX_WR) |-> (x_q >= x0_q && x_q <= x1_q && y_q <= y1_q))
		else $error("pixel write outside footprint");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted while busy");
	a_div_done_at_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ffsa_pkg::ST_RES_SUM) |-> !div_busy)
		else $error("resolve used quotient before divider finished");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_film_filtered_sample_accumulator.sv -----
`timescale 1ns / 1ps
module tb_film_filtered_sample_accumulator;
	import ffsa_pkg::*;

	localparam int FILM_W = 64;
	localparam int FILM_H = 64;
	localparam int TAB_SIDE = 16;
	localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
	localparam longint W32_HI = 64'sh7FFF_FFFF;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] cr;
		logic signed [15:0] cg;
		logic signed [15:0] cb;
		logic [7:0]         widx;
		logic signed [15:0] wval;
		logic [15:0]        scale;
		logic [5:0]         col;
		logic [5:0]         row;
	} film_word_t;

	typedef struct {
		logic [1:0]         stat;
		logic signed [23:0] r;
		logic signed [23:0] g;
		logic signed [23:0] b;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [23:0] out_r, out_g, out_b;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_CROP_X_START;
	logic [14:0] cfg_data = '0;
	film_word_t cur_word = '{default: '0};

	film_word_t pending_words[$];
	pixel_result_t expected_pixels[$];

	logic word_taken = 1'b0;
	int send_gap = 0;
	int sink_hold = 0;
	int stall_req = 0;
	int stall_seen = 0;
	bit idle_on = 1'b1;
	int fail_count = 0;
	int checked_count = 0;
	int op_count[4] = '{0, 0, 0, 0};

	int cx0, cy0, cxn, cyn, rad_x, rad_y, inv_x, inv_y;
	logic signed [15:0] wtab[TAB_SIDE * TAB_SIDE];
	longint acc_r[FILM_W * FILM_H];
	longint acc_g[FILM_W * FILM_H];
	longint acc_b[FILM_W * FILM_H];
	longint acc_w[FILM_W * FILM_H];
	longint spl_r[FILM_W * FILM_H];
	longint spl_g[FILM_W * FILM_H];
	longint spl_b[FILM_W * FILM_H];

	always #2 clk = ~clk;

	film_filtered_sample_accumulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(cur_word.op), .pos_x(cur_word.px), .pos_y(cur_word.py),
		.color_r(cur_word.cr), .color_g(cur_word.cg), .color_b(cur_word.cb),
		.weight_index(cur_word.widx), .weight_value(cur_word.wval),
		.splat_scale(cur_word.scale), .pixel_col(cur_word.col), .pixel_row(cur_word.row),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_r(out_r), .out_g(out_g), .out_b(out_b),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int eff_cnt(int c, int lim);
		if (c < 1) return 1;
		if (c > lim) return lim;
		return c;
	endfunction

	function automatic longint sat_sum(longint a, longint b, longint hi);
		if (b > 0 && a > hi - b) return hi;
		if (b < 0 && a < -hi - 1 - b) return -hi - 1;
		return a + b;
	endfunction

	function automatic int tab_slot(int pix, int d, int inv);
		longint diff;
		longint mag;
		longint i;
		diff = longint'(pix) * 16 - d;
		mag = diff < 0 ? -diff : diff;
		i = (mag * inv * TAB_SIDE) >>> 16;
		return i > TAB_SIDE - 1 ? TAB_SIDE - 1 : int'(i);
	endfunction

	function automatic logic signed [23:0] resolve_chan(longint acc, longint w, longint spl,
		longint scale);
		longint c;
		longint q;
		if (w != 0) begin
			q = (acc < 0 ? -acc : acc) / (w < 0 ? -w : w);
			c = ((acc < 0) != (w < 0) || q == 0) ? 0 : q;
		end else begin
			c = acc >>> 15;
		end
		c += (spl * scale) >>> 8;
		if (c > longint'(COLOR_MAX)) c = COLOR_MAX;
		if (c < longint'(COLOR_MIN)) c = COLOR_MIN;
		return c[23:0];
	endfunction

	function automatic pixel_result_t film_apply(film_word_t w);
		pixel_result_t res;
		int xc, yc, dx, dy, x0, x1, y0, y1, x, y, iy, ix, p;
		longint wt;
		res = '{STAT_DONE, 24'sd0, 24'sd0, 24'sd0};
		xc = eff_cnt(cxn, FILM_W);
		yc = eff_cnt(cyn, FILM_H);
		case (w.op)
			OP_LOAD: begin
				wtab[w.widx] = w.wval;
			end
			OP_ADD: begin
				dx = int'(w.px) - 8;
				dy = int'(w.py) - 8;
				x0 = -((-(dx - rad_x)) >>> 4);
				x1 = (dx + rad_x) >>> 4;
				y0 = -((-(dy - rad_y)) >>> 4);
				y1 = (dy + rad_y) >>> 4;
				if (x0 < cx0) x0 = cx0;
				if (x1 > cx0 + xc - 1) x1 = cx0 + xc - 1;
				if (y0 < cy0) y0 = cy0;
				if (y1 > cy0 + yc - 1) y1 = cy0 + yc - 1;
				if (x1 < x0 || y1 < y0) begin
					res.stat = STAT_OUTSIDE;
				end else begin
					for (y = y0; y <= y1; y++) begin
						iy = tab_slot(y, dy, inv_y);
						for (x = x0; x <= x1; x++) begin
							ix = tab_slot(x, dx, inv_x);
							wt = wtab[iy * TAB_SIDE + ix];
							p = (y - cy0) * FILM_W + (x - cx0);
							acc_r[p] = sat_sum(acc_r[p], wt * w.cr, ACC_HI);
							acc_g[p] = sat_sum(acc_g[p], wt * w.cg, ACC_HI);
							acc_b[p] = sat_sum(acc_b[p], wt * w.cb, ACC_HI);
							acc_w[p] = sat_sum(acc_w[p], wt, W32_HI);
						end
					end
				end
			end
			OP_SPLAT: begin
				x = int'(w.px) >>> 4;
				y = int'(w.py) >>> 4;
				if (x < cx0 || x - cx0 >= xc || y < cy0 || y - cy0 >= yc) begin
					res.stat = STAT_OUTSIDE;
				end else begin
					p = (y - cy0) * FILM_W + (x - cx0);
					spl_r[p] = sat_sum(spl_r[p], w.cr, W32_HI);
					spl_g[p] = sat_sum(spl_g[p], w.cg, W32_HI);
					spl_b[p] = sat_sum(spl_b[p], w.cb, W32_HI);
				end
			end
			default: begin
				if (int'(w.col) >= xc || int'(w.row) >= yc) begin
					res.stat = STAT_NO_PIXEL;
				end else begin
					p = int'(w.row) * FILM_W + int'(w.col);
					res.r = resolve_chan(acc_r[p], acc_w[p], spl_r[p], w.scale);
					res.g = resolve_chan(acc_g[p], acc_w[p], spl_g[p], w.scale);
					res.b = resolve_chan(acc_b[p], acc_w[p], spl_b[p], w.scale);
				end
			end
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!idle_on || roll < 70) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 80);
	endfunction

	always @(negedge clk) begin
		film_word_t nxt;
		logic v;
		nxt = cur_word;
		v = in_valid;
		if (!in_valid || word_taken) begin
			v = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_words.size() != 0) begin
				nxt = pending_words.pop_front();
				v = 1'b1;
				send_gap = pick_gap();
			end
		end
		in_valid <= v;
		cur_word <= nxt;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_pixels.push_back(film_apply(cur_word));
			op_count[cur_word.op]++;
			word_taken <= 1'b1;
		end else begin
			word_taken <= 1'b0;
		end
	end

	always @(negedge clk) begin
		logic r;
		int roll;
		r = 1'b1;
		if (stall_seen != stall_req) begin
			stall_seen = stall_req;
			sink_hold = 400;
		end
		if (sink_hold > 0) begin
			sink_hold--;
			r = 1'b0;
		end else if (idle_on) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) sink_hold = $urandom_range(15, 60);
			else if (roll < 18) sink_hold = $urandom_range(1, 3);
		end
		out_ready <= r;
	end

	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && out_valid && out_ready) begin
			checked_count++;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected word status=%0d r=%0d g=%0d b=%0d",
					$realtime, status, out_r, out_g, out_b);
				fail_count++;
			end else begin
				e = expected_pixels.pop_front();
				if (status !== e.stat) begin
					$display("%0t: status expected %0d actual %0d", $realtime, e.stat, status);
					fail_count++;
				end
				if (out_r !== e.r) begin
					$display("%0t: out_r expected %0d actual %0d", $realtime, e.r, out_r);
					fail_count++;
				end
				if (out_g !== e.g) begin
					$display("%0t: out_g expected %0d actual %0d", $realtime, e.g, out_g);
					fail_count++;
				end
				if (out_b !== e.b) begin
					$display("%0t: out_b expected %0d actual %0d", $realtime, e.b, out_b);
					fail_count++;
				end
			end
		end
	end

	function automatic film_word_t rand_word();
		film_word_t w;
		w.op = 2'($urandom);
		w.px = 16'($urandom);
		w.py = 16'($urandom);
		w.cr = 16'($urandom);
		w.cg = 16'($urandom);
		w.cb = 16'($urandom);
		w.widx = 8'($urandom);
		w.wval = 16'($urandom);
		w.scale = 16'($urandom);
		w.col = 6'($urandom);
		w.row = 6'($urandom);
		return w;
	endfunction

	function automatic logic signed [15:0] pos_near(int start, int cnt, int rad);
		int m;
		m = rad / 16 + 1;
		return 16'((start + $urandom_range(0, cnt + 2 * m) - m) * 16 + $urandom_range(0, 15));
	endfunction

	function automatic film_word_t gen_word();
		film_word_t w;
		int roll, xc, yc;
		w = rand_word();
		roll = $urandom_range(0, 99);
		xc = eff_cnt(cxn, FILM_W);
		yc = eff_cnt(cyn, FILM_H);
		if (roll < 8) return w;
		if (roll < 18) begin
			w.op = OP_LOAD;
		end else if (roll < 72) begin
			w.op = roll < 55 ? OP_ADD : OP_SPLAT;
			w.px = pos_near(cx0, xc, rad_x);
			w.py = pos_near(cy0, yc, rad_y);
		end else begin
			w.op = OP_RESOLVE;
			w.col = 6'($urandom_range(0, xc));
			w.row = 6'($urandom_range(0, yc));
		end
		return w;
	endfunction

	task automatic cfg_write(logic [2:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 15'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CROP_X_START: cx0 = val & 'h7FF;
			REG_CROP_Y_START: cy0 = val & 'h7FF;
			REG_CROP_X_COUNT: cxn = val & 'h7F;
			REG_CROP_Y_COUNT: cyn = val & 'h7F;
			REG_RADIUS_X:     rad_x = val & 'h7F;
			REG_RADIUS_Y:     rad_y = val & 'h7F;
			REG_INV_RADIUS_X: inv_x = val & 'h7FFF;
			default:          inv_y = val & 'h7FFF;
		endcase
	endtask

	task automatic set_film(int xs, int ys, int xn, int yn, int rx, int ry, int ix, int iy);
		cfg_write(REG_CROP_X_START, xs);
		cfg_write(REG_CROP_Y_START, ys);
		cfg_write(REG_CROP_X_COUNT, xn);
		cfg_write(REG_CROP_Y_COUNT, yn);
		cfg_write(REG_RADIUS_X, rx);
		cfg_write(REG_RADIUS_Y, ry);
		cfg_write(REG_INV_RADIUS_X, ix);
		cfg_write(REG_INV_RADIUS_Y, iy);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic push_random(int n);
		repeat (n) pending_words.push_back(gen_word());
	endtask

	initial begin
		film_word_t w;
		int rx, ry;
		cx0 = 0; cy0 = 0; cxn = 64; cyn = 64;
		rad_x = 8; rad_y = 8; inv_x = 8192; inv_y = 8192;
		foreach (acc_r[i]) begin
			acc_r[i] = 0; acc_g[i] = 0; acc_b[i] = 0; acc_w[i] = 0;
			spl_r[i] = 0; spl_g[i] = 0; spl_b[i] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the whole weight table before any add can read it
		for (int i = 0; i < TAB_SIDE * TAB_SIDE; i++) begin
			w = rand_word();
			w.op = OP_LOAD;
			w.widx = 8'(i);
			if (i == 0) w.wval = 16'sh7FFF;
			if (i == 255) w.wval = -16'sh8000;
			pending_words.push_back(w);
		end

		w = rand_word(); w.op = OP_RESOLVE; w.col = 0; w.row = 0; w.scale = 16'hFFFF;
		pending_words.push_back(w);
		w = rand_word(); w.op = OP_ADD; w.px = 16'sd8; w.py = 16'sd8;
		w.cr = 16'sh7FFF; w.cg = -16'sh8000; w.cb = 16'sd0;
		pending_words.push_back(w);
		w.px = 16'sd1016; w.py = 16'sd1016; w.cr = -16'sh8000; w.cg = 16'sh7FFF;
		pending_words.push_back(w);
		w.px = -16'sh8000; w.py = -16'sh8000;
		pending_words.push_back(w);
		w.px = 16'sh7FFF; w.py = 16'sh7FFF;
		pending_words.push_back(w);
		w.op = OP_SPLAT; w.px = 16'sd0; w.py = 16'sd0;
		w.cr = 16'sh7FFF; w.cg = -16'sh8000; w.cb = -16'sd1;
		pending_words.push_back(w);
		w.px = 16'sd1023; w.py = 16'sd1023;
		pending_words.push_back(w);
		w.px = -16'sd1; w.py = 16'sd0;
		pending_words.push_back(w);
		w.px = 16'sd1024; w.py = 16'sd5;
		pending_words.push_back(w);
		w = rand_word(); w.op = OP_RESOLVE; w.col = 0; w.row = 0; w.scale = 16'hFFFF;
		pending_words.push_back(w);
		w.scale = 16'h0000;
		pending_words.push_back(w);
		w.col = 63; w.row = 63; w.scale = 16'h0100;
		pending_words.push_back(w);
		w.col = 1; w.row = 0;
		pending_words.push_back(w);
		w.col = 0; w.row = 1;
		pending_words.push_back(w);
		w = rand_word(); w.op = OP_LOAD; w.widx = 8'hFF; w.wval = 16'sh7FFF;
		pending_words.push_back(w);
		drain();

		set_film(0, 0, 64, 64, 64, 64, 1024, 1024);
		push_random(40);
		drain();

		set_film(2047, 2047, 1, 1, 2, 2, 32767, 32767);
		push_random(60);
		drain();
		w = rand_word(); w.op = OP_RESOLVE; w.col = 1; w.row = 0;
		pending_words.push_back(w);
		drain();

		set_film(100, 37, 0, 127, 127, 127, 256, 256);
		push_random(40);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			rx = $urandom_range(2, 24);
			ry = $urandom_range(2, 24);
			set_film($urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(1, 64), $urandom_range(1, 64), rx, ry,
				$urandom_range(0, 3) == 0 ? $urandom_range(256, 32767)
					: (65536 / rx > 32767 ? 32767 : 65536 / rx),
				65536 / ry > 32767 ? 32767 : 65536 / ry);
			if (ph == 1) set_film(0, 0, 64, 64, rx, ry, 65536 / rx, 65536 / ry);
			idle_on = (ph != 2);
			if (ph == 3) stall_req++;
			push_random(100);
			drain();
			push_random(100);
			drain();
		end
		idle_on = 1'b1;

		$display("Covered %0d loads, %0d adds, %0d splats, %0d resolves; %0d words checked",
			op_count[OP_LOAD], op_count[OP_ADD], op_count[OP_SPLAT], op_count[OP_RESOLVE],
			checked_count);
		$display("Crop extremes, clamped counts and oversized radii were exercised.");
		if (fail_count == 0 && expected_pixels.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ffsa_pkg.sv
src/ffsa_div.sv
src/film_filtered_sample_accumulator.sv
tb/tb_film_filtered_sample_accumulator.sv
